// ===== rtl/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg: shared definitions for the sphere frustum cull block
// Register indexes, field widths, result codes and slice helpers.
// ----------------------------------------------------------------------------
package sfc_pkg;

  // Plane count limits
  localparam int NUM_PLANES_DEF = 4;
  localparam int NUM_PLANES_MAX = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE0  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_XFORM_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISABLE = 4'd7;

  // Field widths
  localparam int COORD_W = 16;
  localparam int XPROD_W = 2 * COORD_W;        // point x axis weight
  localparam int WORLD_W = XPROD_W + 2;        // world centre in Q.14
  localparam int PPROD_W = WORLD_W + COORD_W;  // world centre x normal
  localparam int DIST_W  = PPROD_W + 2;        // plane distance in Q.28
  localparam int FRAC_W  = 14;
  localparam int FRAC2_W = 2 * FRAC_W;

  // Stream data widths
  localparam int IN_DATA_W  = 4 * COORD_W;
  localparam int OUT_DATA_W = 8;

  // Result codes
  typedef enum logic [1:0] {
    RES_INSIDE  = 2'd0,
    RES_CLIPPED = 2'd1,
    RES_OUTSIDE = 2'd2
  } cull_res_t;

  // Signed 16-bit slice of a packed register word
  function automatic logic signed [COORD_W-1:0] slice16(input logic [CFG_DATA_W-1:0] word,
                                                       input int idx);
    slice16 = $signed(word[idx*COORD_W +: COORD_W]);
  endfunction

endpackage

// ===== rtl/sphere_frustum_cull_top.sv =====
// ----------------------------------------------------------------------------
// sphere_frustum_cull_top: sphere against frustum classifier
// Maps a sphere centre to world space when asked, tests it against the
// frustum planes and reports inside, clipped or outside.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sphere per request. in_tdata holds point_x, point_y, point_z,
//           sphere_radius; in_tuser is point_is_local.
//   out_* : one result per request, cull_result in out_tdata[1:0].
//   cfg_* : register writes (planes, transform columns, cull disable). Write
//           only while no request is in flight; cfg_ready is always high.
// Pipeline: six register stages (input register, transform products, transform
//   sums, plane products, plane sums, compare into the output register).
// Throughput: one request per cycle while out_tready is high; every stage
//   after the input register holds one level of multiplies, one multi-operand
//   sum or one compare, so nothing iterates.
// Reset: configuration registers and valid bits clear; planes and transform read as
//   zero, so every sphere reports clipped until written.
// Stall: when out_tready is low the output register holds its result and
//   each stage keeps moving while a bubble lies ahead of it; in_tready drops
//   only once every stage is full.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_top #(
  parameter int NUM_PLANES = sfc_pkg::NUM_PLANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input: [15:0] point_x, [31:16] point_y, [47:32] point_z, [63:48] sphere_radius
  input  logic [sfc_pkg::IN_DATA_W-1:0]     in_tdata,
  // Input user: [0] point_is_local
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Output: [1:0] cull_result, [7:2] zero
  output logic [sfc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Configuration write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = sfc_pkg::COORD_W;
  localparam int XW = sfc_pkg::XPROD_W;
  localparam int WW = sfc_pkg::WORLD_W;
  localparam int PW = sfc_pkg::PPROD_W;
  localparam int DW = sfc_pkg::DIST_W;
  localparam int FW = sfc_pkg::FRAC_W;
  localparam int F2 = sfc_pkg::FRAC2_W;
  localparam int NSTG = 6;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [sfc_pkg::CFG_DATA_W-1:0] plane_r [NUM_PLANES];
  logic [sfc_pkg::CFG_DATA_W-1:0] xform_r [3];
  logic                           disable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) plane_r[i] <= '0;
      for (int a = 0; a < 3; a++) xform_r[a] <= '0;
      disable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (cfg_index == sfc_pkg::REG_PLANE0 + sfc_pkg::CFG_IDX_W'(i)) plane_r[i] <= cfg_data;
      end
      for (int a = 0; a < 3; a++) begin
        if (cfg_index == sfc_pkg::REG_XFORM_X + sfc_pkg::CFG_IDX_W'(a)) xform_r[a] <= cfg_data;
      end
      if (cfg_index == sfc_pkg::REG_DISABLE) disable_r <= cfg_data[0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int s = NSTG-2; s >= 0; s--) en[s] = !vld_r[s] || en[s+1];
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] pt0_r [3];
  logic [CW-1:0]        rad0_r;
  logic                 loc0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) pt0_r[a] <= $signed(in_tdata[a*CW +: CW]);
      rad0_r <= in_tdata[3*CW +: CW];
      loc0_r <= in_tuser;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: transform products, one per axis weight
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] xprod_nxt [3][3];
  logic signed [XW-1:0] xprod_r   [3][3];
  logic signed [CW-1:0] pt1_r [3];
  logic [CW-1:0]        rad1_r;
  logic                 loc1_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        xprod_nxt[a][k] = pt0_r[k] * sfc_pkg::slice16(xform_r[a], k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xprod_r <= xprod_nxt;
      pt1_r   <= pt0_r;
      rad1_r  <= rad0_r;
      loc1_r  <= loc0_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: world centre in Q.14
  // --------------------------------------------------------------------------
  logic signed [WW-1:0] world_nxt [3];
  logic signed [WW-1:0] world_r   [3];
  logic [CW-1:0]        rad2_r;

  always_comb begin
    logic signed [CW-1:0] org;
    for (int a = 0; a < 3; a++) begin
      org = sfc_pkg::slice16(xform_r[a], 3);
      if (loc1_r) begin
        world_nxt[a] = WW'(xprod_r[a][0]) + WW'(xprod_r[a][1]) + WW'(xprod_r[a][2])
                     + $signed({{(WW-CW-FW){org[CW-1]}}, org, {FW{1'b0}}});
      end else begin
        world_nxt[a] = $signed({{(WW-CW-FW){pt1_r[a][CW-1]}}, pt1_r[a], {FW{1'b0}}});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      world_r <= world_nxt;
      rad2_r  <= rad1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: plane products, world centre times normal
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] pprod_nxt [NUM_PLANES][3];
  logic signed [PW-1:0] pprod_r   [NUM_PLANES][3];
  logic [CW-1:0]        rad3_r;

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      for (int k = 0; k < 3; k++) begin
        pprod_nxt[i][k] = world_r[k] * sfc_pkg::slice16(plane_r[i], k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pprod_r <= pprod_nxt;
      rad3_r  <= rad2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: signed plane distances in Q.28
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] dist_nxt [NUM_PLANES];
  logic signed [DW-1:0] dist_r   [NUM_PLANES];
  logic [CW-1:0]        rad4_r;

  always_comb begin
    logic signed [CW-1:0] pd;
    for (int i = 0; i < NUM_PLANES; i++) begin
      pd = sfc_pkg::slice16(plane_r[i], 3);
      dist_nxt[i] = DW'(pprod_r[i][0]) + DW'(pprod_r[i][1]) + DW'(pprod_r[i][2])
                  - $signed({{(DW-CW-F2){pd[CW-1]}}, pd, {F2{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      dist_r <= dist_nxt;
      rad4_r <= rad3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: classify into the output register
  // Any plane fully behind wins over clipping by an earlier plane.
  // --------------------------------------------------------------------------
  sfc_pkg::cull_res_t res_nxt;
  sfc_pkg::cull_res_t res_r;

  always_comb begin
    logic signed [DW-1:0] r28;
    logic signed [DW-1:0] nr28;
    logic                 any_out;
    logic                 any_clip;
    r28      = $signed({{(DW-CW-F2){1'b0}}, rad4_r, {F2{1'b0}}});
    nr28     = -r28;
    any_out  = 1'b0;
    any_clip = 1'b0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      if (dist_r[i] < nr28) any_out = 1'b1;
      if (dist_r[i] <= r28) any_clip = 1'b1;
    end
    if (disable_r)     res_nxt = sfc_pkg::RES_CLIPPED;
    else if (any_out)  res_nxt = sfc_pkg::RES_OUTSIDE;
    else if (any_clip) res_nxt = sfc_pkg::RES_CLIPPED;
    else               res_nxt = sfc_pkg::RES_INSIDE;
  end

  always_ff @(posedge clk) begin
    if (en[5]) res_r <= res_nxt;
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {{(sfc_pkg::OUT_DATA_W-2){1'b0}}, res_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Disabled culling only ever reports clipped
  a_disable_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && disable_r |-> res_r == sfc_pkg::RES_CLIPPED)
    else $error("result not clipped while culling disabled");

  // Result code is never the unused value
  a_res_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_r != 2'd3)
    else $error("unused result code on output");

  // Input stalls only with every stage full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> &vld_r)
    else $error("input stalled with a bubble in the pipeline");

  // A loaded plane-sum stage reaches the output next cycle
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-2] && en[NSTG-1] |=> out_tvalid)
    else $error("result lost between last two stages");

endmodule

// ===== bench/sphere_frustum_cull_top_tb.sv =====
// ----------------------------------------------------------------------------
// sphere_frustum_cull_top_tb: self-checking bench for the sphere cull block
// Programs planes, transform columns and the cull disable bit between phases,
// streams spheres in bursts against a stalling receiver, and compares every
// cull result with an in-bench classifier that tracks the same registers.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_top_tb;

  localparam int PLANE_COUNT = sfc_pkg::NUM_PLANES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PAD    = 10;     // a little over the depth of the six-stage pipeline
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 80;

  localparam logic [15:0] Q_ONE  = 16'h4000;  // +1.0 in Q2.14
  localparam logic [15:0] Q_NEG1 = 16'hC000;  // -1.0 in Q2.14
  localparam logic [sfc_pkg::CFG_IDX_W-1:0] REG_IDX_MAX = {sfc_pkg::CFG_IDX_W{1'b1}};

  logic                           clk;
  logic                           rst_n;
  logic [sfc_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tuser;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [sfc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [sfc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sfc_pkg::CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the block's registers
  logic [sfc_pkg::CFG_DATA_W-1:0] plane_words [PLANE_COUNT];
  logic [sfc_pkg::CFG_DATA_W-1:0] axis_words  [3];
  logic                           cull_off;

  sfc_pkg::cull_res_t cull_expected [$];
  sfc_pkg::cull_res_t want_res;
  int        err_count;
  int        sent_count;
  int        write_count;
  int        cycle_count;
  int        tally [3];
  int        stall_mode;   // 0 always ready, 1 short stalls, 2 long stalls
  int        stall_left;

  sphere_frustum_cull_top #(.NUM_PLANES(PLANE_COUNT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, cull_expected.size());
      $display("sphere_frustum_cull_top_tb NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (stall_mode == 0) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, (stall_mode == 2) ? 24 : 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cull_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none actual cull_result %0d",
                 $time, out_tdata[1:0]);
        err_count++;
      end else begin
        want_res = cull_expected.pop_front();
        tally[want_res]++;
        if (out_tdata[1:0] !== want_res) begin
          $display("%0t: cull_result mismatch, expected %0d actual %0d",
                   $time, want_res, out_tdata[1:0]);
          err_count++;
        end
      end
    end
  end

  function automatic longint sx(input logic [15:0] v);
    longint s;
    s = $signed(v);
    return s;
  endfunction

  function automatic logic [15:0] s16(input int v);
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_s16(input int lim);
    return s16(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic logic [15:0] extreme_slice();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pack_word(input logic [15:0] s0, s1, s2, s3);
    return {s3, s2, s1, s0};
  endfunction

  // Register index at an offset from a base index
  function automatic logic [sfc_pkg::CFG_IDX_W-1:0] reg_at(
    input logic [sfc_pkg::CFG_IDX_W-1:0] base, input int off);
    logic [sfc_pkg::CFG_IDX_W-1:0] step;
    step = off[sfc_pkg::CFG_IDX_W-1:0];
    return base + step;
  endfunction

  // Classify a sphere against the shadow registers, exact in Q.28
  function automatic sfc_pkg::cull_res_t classify_sphere(input logic [15:0] px, py, pz,
                                                         input logic [15:0] rad,
                                                         input logic loc);
    longint cen [3];
    longint wc [3];
    longint r28;
    longint plane_d;
    bit     clip;
    cen[0] = sx(px);
    cen[1] = sx(py);
    cen[2] = sx(pz);
    r28 = rad;
    r28 = r28 <<< sfc_pkg::FRAC2_W;
    clip = 1'b0;
    if (cull_off)
      return sfc_pkg::RES_CLIPPED;
    // World centre in Q.14
    for (int a = 0; a < 3; a++) begin
      if (loc)
        wc[a] = cen[0] * sx(axis_words[a][15:0]) + cen[1] * sx(axis_words[a][31:16])
              + cen[2] * sx(axis_words[a][47:32])
              + (sx(axis_words[a][63:48]) <<< sfc_pkg::FRAC_W);
      else
        wc[a] = cen[a] <<< sfc_pkg::FRAC_W;
    end
    // Planes in order; a sphere fully behind one ends the test
    for (int i = 0; i < PLANE_COUNT; i++) begin
      plane_d = wc[0] * sx(plane_words[i][15:0]) + wc[1] * sx(plane_words[i][31:16])
              + wc[2] * sx(plane_words[i][47:32])
              - (sx(plane_words[i][63:48]) <<< sfc_pkg::FRAC2_W);
      if (plane_d < -r28)
        return sfc_pkg::RES_OUTSIDE;
      if (plane_d <= r28)
        clip = 1'b1;
    end
    return clip ? sfc_pkg::RES_CLIPPED : sfc_pkg::RES_INSIDE;
  endfunction

  // One sphere request; leaves in_tvalid high for a following request
  task automatic send_sphere(input logic [15:0] px, py, pz, rad, input logic loc);
    in_tdata  <= {rad, pz, py, px};
    in_tuser  <= loc;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cull_expected.push_back(classify_sphere(px, py, pz, rad, loc));
    sent_count++;
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic wait_idle();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (cull_expected.size() != 0) @(negedge clk);
    repeat (IDLE_PAD) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < sfc_pkg::REG_XFORM_X)
      plane_words[idx - sfc_pkg::REG_PLANE0] = data;
    else if (idx < sfc_pkg::REG_DISABLE)
      axis_words[idx - sfc_pkg::REG_XFORM_X] = data;
    else if (idx == sfc_pkg::REG_DISABLE)
      cull_off = data[0];
    write_count++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers still at reset: everything reads as clipped
  task automatic test_reset_state();
    stall_mode = 0;
    send_sphere(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1);
    send_sphere(16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    send_sphere(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sphere(16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 1'b1);
    wait_idle();
  endtask

  // Box-shaped frustum: exact touching, plane order, transform with origin
  task automatic test_plane_boundaries();
    write_reg(reg_at(sfc_pkg::REG_PLANE0, 0),
              pack_word(Q_ONE, 16'h0, 16'h0, 16'h0));           // d = x
    write_reg(reg_at(sfc_pkg::REG_PLANE0, 1),
              pack_word(16'h0, Q_ONE, 16'h0, s16(100)));        // d = y - 100
    write_reg(reg_at(sfc_pkg::REG_PLANE0, 2),
              pack_word(16'h0, 16'h0, Q_ONE, s16(-1000)));      // d = z + 1000
    write_reg(reg_at(sfc_pkg::REG_PLANE0, 3),
              pack_word(Q_NEG1, 16'h0, 16'h0, s16(-1000)));     // d = 1000 - x
    write_reg(sfc_pkg::REG_XFORM_X, pack_word(Q_ONE, 16'h0, 16'h0, s16(400)));
    write_reg(reg_at(sfc_pkg::REG_XFORM_X, 1), pack_word(16'h0, Q_ONE, 16'h0, s16(300)));
    write_reg(reg_at(sfc_pkg::REG_XFORM_X, 2), pack_word(16'h0, 16'h0, Q_ONE, 16'h0));
    write_reg(sfc_pkg::REG_DISABLE, 64'h0);
    send_sphere(s16(500), s16(300), 16'h0, s16(10), 1'b0);   // inside
    send_sphere(s16(10), s16(300), 16'h0, s16(10), 1'b0);    // touching +r
    send_sphere(s16(-10), s16(300), 16'h0, s16(10), 1'b0);   // touching -r
    send_sphere(s16(-11), s16(300), 16'h0, s16(10), 1'b0);   // just behind
    send_sphere(s16(5), 16'h0, 16'h0, s16(10), 1'b0);        // clipped, then behind
    send_sphere(16'h0, s16(300), 16'h0, 16'h0, 1'b0);        // zero radius on plane
    send_sphere(s16(1), s16(300), 16'h0, 16'h0, 1'b0);       // zero radius inside
    send_sphere(s16(2000), s16(300), 16'h0, s16(10), 1'b0);  // behind last plane only
    send_sphere(s16(100), 16'h0, 16'h0, s16(10), 1'b1);      // local, inside
    send_sphere(s16(-390), 16'h0, 16'h0, s16(10), 1'b1);     // local, touching
    send_sphere(s16(-411), 16'h0, 16'h0, s16(10), 1'b1);     // local, behind
    wait_idle();
  endtask

  // Widest products: all slices at the Q2.14 extremes
  task automatic test_extreme_registers();
    logic [15:0] fill;
    for (int pass = 0; pass < 2; pass++) begin
      fill = (pass == 0) ? 16'h8000 : 16'h7FFF;
      for (int i = 0; i < PLANE_COUNT; i++)
        write_reg(reg_at(sfc_pkg::REG_PLANE0, i), {4{fill}});
      for (int a = 0; a < 3; a++)
        write_reg(reg_at(sfc_pkg::REG_XFORM_X, a), {4{fill}});
      send_sphere(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b1);
      send_sphere(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
      send_sphere(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b0);
      wait_idle();
    end
  endtask

  // Disable bit: only bit 0 counts; unused indexes change nothing
  task automatic test_cull_disable();
    write_reg(sfc_pkg::REG_DISABLE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_sphere(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0);
    wait_idle();
    write_reg(sfc_pkg::REG_DISABLE, 64'h8000_0000_0000_0001);
    send_sphere(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0);
    send_sphere(16'h8000, 16'h0000, 16'h7FFF, 16'h0001, 1'b1);
    wait_idle();
    for (int j = sfc_pkg::REG_DISABLE + 1; j <= REG_IDX_MAX; j++)
      write_reg(j[sfc_pkg::CFG_IDX_W-1:0], {$urandom, $urandom});
    write_reg(sfc_pkg::REG_DISABLE, 64'h0);
    send_sphere(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0);
    send_sphere(16'h8000, 16'h0000, 16'h7FFF, 16'h0001, 1'b1);
    wait_idle();
  endtask

  // Register set for one random phase
  task automatic program_scene(input int style, input bit disable_on);
    logic [63:0] word;
    int          spare;
    for (int r = 0; r < PLANE_COUNT + 3; r++) begin
      case (style)
        0: word = pack_word(pick_s16(16384), pick_s16(16384), pick_s16(16384), pick_s16(2000));
        1: word = {$urandom, $urandom};
        default: word = pack_word(extreme_slice(), extreme_slice(), extreme_slice(),
                                  extreme_slice());
      endcase
      if (r < PLANE_COUNT)
        write_reg(reg_at(sfc_pkg::REG_PLANE0, r), word);
      else
        write_reg(reg_at(sfc_pkg::REG_XFORM_X, r - PLANE_COUNT), word);
    end
    word = {$urandom, $urandom};
    word[0] = disable_on;
    write_reg(sfc_pkg::REG_DISABLE, word);
    if ($urandom_range(0, 1)) begin
      spare = int'($urandom_range(sfc_pkg::REG_DISABLE + 1, REG_IDX_MAX));
      write_reg(spare[sfc_pkg::CFG_IDX_W-1:0], {$urandom, $urandom});
    end
  endtask

  // Bursts of random spheres with random gaps
  task automatic stream_spheres(input int count, input int gap_max, input bit near_pts);
    int          burst_left;
    int          gap;
    logic [15:0] c [3];
    logic [15:0] rad;
    burst_left = $urandom_range(1, 16);
    for (int k = 0; k < count; k++) begin
      for (int a = 0; a < 3; a++)
        c[a] = (near_pts && $urandom_range(0, 9) < 7) ? pick_s16(2000) : 16'($urandom);
      case ($urandom_range(0, 9))
        0:       rad = 16'h0000;
        1:       rad = 16'hFFFF;
        2, 3:    rad = 16'($urandom);
        default: rad = 16'($urandom_range(0, 3000));
      endcase
      send_sphere(c[0], c[1], c[2], rad, 1'($urandom_range(0, 1)));
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = (gap_max != 0) ? $urandom_range(0, gap_max) : 0;
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  task automatic test_random_scenes();
    int style;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      style = ph % 3;
      stall_mode = (ph == 0) ? 0 : 1 + (ph % 2);
      program_scene(style, ph == 4);
      stream_spheres(PHASE_ITEMS, (ph == 0) ? 0 : ((ph % 3 == 2) ? 2 : 10),
                     style == 0 || ph >= 6);
      wait_idle();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tvalid  = 1'b0;
    out_tready = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    err_count   = 0;
    sent_count  = 0;
    write_count = 0;
    cycle_count = 0;
    stall_mode  = 0;
    stall_left  = 0;
    tally = '{0, 0, 0};
    for (int i = 0; i < PLANE_COUNT; i++) plane_words[i] = '0;
    for (int a = 0; a < 3; a++) axis_words[a] = '0;
    cull_off = 1'b0;

    // Synchronous reset, released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_plane_boundaries();
    test_extreme_registers();
    test_cull_disable();
    test_random_scenes();

    wait_idle();
    $display("spheres sent %0d over %0d register writes", sent_count, write_count);
    $display("results: %0d inside, %0d clipped, %0d outside, %0d errors",
             tally[sfc_pkg::RES_INSIDE], tally[sfc_pkg::RES_CLIPPED],
             tally[sfc_pkg::RES_OUTSIDE], err_count);
    if (err_count == 0)
      $display("sphere_frustum_cull_top_tb OK");
    else
      $display("sphere_frustum_cull_top_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sfc_pkg.sv
rtl/sphere_frustum_cull_top.sv
bench/sphere_frustum_cull_top_tb.sv
